### rtl/pwli_pkg.sv
`default_nettype none

package pwli_pkg;

  localparam int MAX_KNOTS = 64;
  localparam int ADDR_W    = $clog2(MAX_KNOTS);
  localparam int CNT_W     = 7;
  localparam int DATA_W    = 32;
  localparam int FRAC_W    = 16;
  localparam int QUOT_W    = DATA_W + FRAC_W;
  localparam int DIV_STEPS = QUOT_W;
  localparam int MUL_STEPS = DATA_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic [CNT_W-1:0] KNOT_COUNT_RESET = CNT_W'(2);
  localparam logic [CNT_W-1:0] KNOT_COUNT_MIN   = CNT_W'(2);
  localparam logic [CNT_W-1:0] KNOT_COUNT_MAX   = CNT_W'(MAX_KNOTS);

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_FIRST,
    ST_RD_LAST,
    ST_SCAN,
    ST_DIV,
    ST_MUL,
    ST_DONE
  } pwli_state_t;

  typedef struct packed {
    logic              wr_en;
    logic              load_q;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              cap_first;
    logic              cap_last;
    logic              shift_prev;
    logic              seg_load;
    logic              div_step;
    logic              mul_step;
    logic              emit;
    logic              found;
  } pwli_cmd_t;

  typedef struct packed {
    logic hit;
    logic outside;
  } pwli_sts_t;

endpackage

`default_nettype wire

### rtl/pwli_datapath.sv
`default_nettype none

module pwli_datapath
  import pwli_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire pwli_cmd_t                cmd,
  output pwli_sts_t                     sts,
  input  wire logic [ADDR_W-1:0]        in_knot_index,
  input  wire logic signed [DATA_W-1:0] in_knot_x,
  input  wire logic signed [DATA_W-1:0] in_knot_y,
  input  wire logic signed [DATA_W-1:0] in_query_x,
  output logic                          out_valid,
  output logic signed [DATA_W-1:0]      out_value_y,
  output logic                          out_in_range
);

  logic signed [DATA_W-1:0] mem_x [MAX_KNOTS];
  logic signed [DATA_W-1:0] mem_y [MAX_KNOTS];

  logic signed [DATA_W-1:0] rd_x_r, rd_y_r;
  logic signed [DATA_W-1:0] q_r, first_x_r, last_x_r, prev_x_r, prev_y_r;
  logic [DATA_W-1:0]        den_r, rem_r, dq_r;
  logic [QUOT_W-1:0]        num_r, acc_r;
  logic                     neg_r, zero_r;
  logic                     out_valid_r, out_in_range_r;
  logic signed [DATA_W-1:0] out_value_y_r;

  logic signed [DATA_W:0]   dx, dy, dq, dy_mag;
  logic [DATA_W+1:0]        trial;
  logic signed [QUOT_W+1:0] prod;
  logic signed [QUOT_W+1-FRAC_W:0] term;
  logic signed [QUOT_W+2-FRAC_W:0] sum;
  logic signed [DATA_W-1:0] sat;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem_x[in_knot_index] <= in_knot_x;
      mem_y[in_knot_index] <= in_knot_y;
    end
    if (cmd.rd_en) begin
      rd_x_r <= mem_x[cmd.rd_addr];
      rd_y_r <= mem_y[cmd.rd_addr];
    end
  end

  always_comb begin
    sts.hit     = (q_r >= prev_x_r) && (q_r <= rd_x_r);
    sts.outside = (q_r > last_x_r) || (q_r < first_x_r);
  end

  always_comb begin
    dx     = (DATA_W+1)'(rd_x_r) - (DATA_W+1)'(prev_x_r);
    dy     = (DATA_W+1)'(rd_y_r) - (DATA_W+1)'(prev_y_r);
    dq     = (DATA_W+1)'(q_r) - (DATA_W+1)'(prev_x_r);
    dy_mag = dy[DATA_W] ? -dy : dy;
    trial  = {1'b0, rem_r, num_r[QUOT_W-1]} - {2'b00, den_r};
    prod   = neg_r ? -$signed({2'b00, acc_r}) : $signed({2'b00, acc_r});
    term   = prod[QUOT_W+1:FRAC_W];
    sum    = (QUOT_W+3-FRAC_W)'(prev_y_r) + (QUOT_W+3-FRAC_W)'(term);
    if (sum > $signed((QUOT_W+3-FRAC_W)'({1'b0, {(DATA_W-1){1'b1}}}))) begin
      sat = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (sum < -$signed((QUOT_W+3-FRAC_W)'({1'b1, {(DATA_W-1){1'b0}}}))) begin
      sat = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sat = sum[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_q) begin
      q_r <= in_query_x;
    end
    if (cmd.cap_first) begin
      first_x_r <= rd_x_r;
      prev_x_r  <= rd_x_r;
      prev_y_r  <= rd_y_r;
    end else if (cmd.shift_prev) begin
      prev_x_r <= rd_x_r;
      prev_y_r <= rd_y_r;
    end
    if (cmd.cap_last) begin
      last_x_r <= rd_x_r;
    end
    if (cmd.seg_load) begin
      den_r  <= dx[DATA_W-1:0];
      rem_r  <= '0;
      num_r  <= {dy_mag[DATA_W-1:0], {FRAC_W{1'b0}}};
      neg_r  <= dy[DATA_W];
      zero_r <= (dx == '0);
      dq_r   <= dq[DATA_W-1:0];
      acc_r  <= '0;
    end else if (cmd.div_step) begin
      if (!trial[DATA_W+1]) begin
        rem_r <= trial[DATA_W-1:0];
        num_r <= {num_r[QUOT_W-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[DATA_W-2:0], num_r[QUOT_W-1]};
        num_r <= {num_r[QUOT_W-2:0], 1'b0};
      end
    end else if (cmd.mul_step) begin
      acc_r <= {acc_r[QUOT_W-2:0], 1'b0} + ((dq_r[DATA_W-1] && !zero_r) ? num_r : '0);
      dq_r  <= {dq_r[DATA_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_value_y_r  <= cmd.found ? sat : '0;
      out_in_range_r <= cmd.found;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_value_y  = out_value_y_r;
  assign out_in_range = out_in_range_r;

endmodule

`default_nettype wire

### rtl/pwli_controller.sv
`default_nettype none

module pwli_controller
  import pwli_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic             in_action,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CNT_W-1:0] cfg_knot_count,
  input  wire pwli_sts_t        sts,
  output pwli_cmd_t             cmd
);

  pwli_state_t       state_r, state_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              found_r, found_nxt;
  logic [CNT_W-1:0]  knot_count_r;
  logic [CNT_W-1:0]  n_eff;
  logic [ADDR_W-1:0] last_idx;

  assign cfg_ready = 1'b1;
  assign busy      = (state_r != ST_IDLE);

  always_comb begin
    if (knot_count_r < KNOT_COUNT_MIN) begin
      n_eff = KNOT_COUNT_MIN;
    end else if (knot_count_r > KNOT_COUNT_MAX) begin
      n_eff = KNOT_COUNT_MAX;
    end else begin
      n_eff = knot_count_r;
    end
    last_idx = ADDR_W'(n_eff - CNT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      idx_r        <= '0;
      step_r       <= '0;
      found_r      <= 1'b0;
      knot_count_r <= KNOT_COUNT_RESET;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      step_r  <= step_nxt;
      found_r <= found_nxt;
      if (cfg_valid && cfg_ready) begin
        knot_count_r <= cfg_knot_count;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    step_nxt  = step_r;
    found_nxt = found_r;
    cmd       = '0;
    cmd.found = found_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_action == ACT_QUERY) begin
            cmd.load_q  = 1'b1;
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = '0;
            found_nxt   = 1'b0;
            state_nxt   = ST_RD_FIRST;
          end else begin
            cmd.wr_en = 1'b1;
          end
        end
      end
      ST_RD_FIRST: begin
        cmd.cap_first = 1'b1;
        cmd.rd_en     = 1'b1;
        cmd.rd_addr   = last_idx;
        state_nxt     = ST_RD_LAST;
      end
      ST_RD_LAST: begin
        cmd.cap_last = 1'b1;
        cmd.rd_en    = 1'b1;
        cmd.rd_addr  = ADDR_W'(1);
        idx_nxt      = ADDR_W'(1);
        state_nxt    = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.hit) begin
          cmd.seg_load = 1'b1;
          found_nxt    = 1'b1;
          step_nxt     = '0;
          state_nxt    = ST_DIV;
        end else if (sts.outside || idx_r == last_idx) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.shift_prev = 1'b1;
          cmd.rd_en      = 1'b1;
          cmd.rd_addr    = idx_r + ADDR_W'(1);
          idx_nxt        = idx_r + ADDR_W'(1);
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + STEP_W'(1);
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          step_nxt  = '0;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        step_nxt     = step_r + STEP_W'(1);
        if (step_r == STEP_W'(MUL_STEPS - 1)) begin
          step_nxt  = '0;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        cmd.emit  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_scan_index: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> (idx_r != '0) && (idx_r <= last_idx))
    else $error("Scan index has left the knot table.");

  a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_action == ACT_QUERY) |=> state_r == ST_RD_FIRST)
    else $error("Accepted query did not start a table read.");

  a_div_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && step_r == STEP_W'(DIV_STEPS - 1)) |=> state_r == ST_MUL)
    else $error("Division did not hand over to multiplication.");

  a_emit_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> !cmd.emit && state_r == ST_IDLE)
    else $error("Result word was issued twice.");

endmodule

`default_nettype wire

### rtl/piecewise_linear_interpolator.sv
// Channel   Handshake            Payload
// input     start / busy         in_action, in_knot_index, in_knot_x, in_knot_y, in_query_x
// result    out_valid (strobe)   out_value_y, out_in_range
// config    cfg_valid/cfg_ready  cfg_knot_count
//
// A knot write keeps busy low. A query that finds no segment ends after the scan,
// and one that hits goes on to the divider and the multiplier: the linear scan reads
// one knot per cycle from the table memory, then a 48-step serial divider forms the
// slope and a 32-step serial multiplier the offset.
// Reset is synchronous and active low; it sets knot_count to 2 and leaves the tables
// as they are. The result word is shown for one cycle and cannot be stalled.
`default_nettype none

module piecewise_linear_interpolator
  import pwli_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic                     in_action,
  input  wire logic [ADDR_W-1:0]        in_knot_index,
  input  wire logic signed [DATA_W-1:0] in_knot_x,
  input  wire logic signed [DATA_W-1:0] in_knot_y,
  input  wire logic signed [DATA_W-1:0] in_query_x,
  output logic                          out_valid,
  output logic signed [DATA_W-1:0]      out_value_y,
  output logic                          out_in_range,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CNT_W-1:0]         cfg_knot_count
);

  pwli_cmd_t cmd;
  pwli_sts_t sts;

  pwli_controller u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_action      (in_action),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_knot_count (cfg_knot_count),
    .sts            (sts),
    .cmd            (cmd)
  );

  pwli_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_knot_index (in_knot_index),
    .in_knot_x     (in_knot_x),
    .in_knot_y     (in_knot_y),
    .in_query_x    (in_query_x),
    .out_valid     (out_valid),
    .out_value_y   (out_value_y),
    .out_in_range  (out_in_range)
  );

endmodule

`default_nettype wire

### tb/tb_piecewise_linear_interpolator.sv
`timescale 1ns / 1ps

module tb_piecewise_linear_interpolator
  import pwli_pkg::*;
();

  localparam longint Y_MAX = 64'sd2147483647;
  localparam longint Y_MIN = -64'sd2147483648;

  class knot_interp_board;
    logic signed [DATA_W-1:0] abscissa [MAX_KNOTS];
    logic signed [DATA_W-1:0] ordinate [MAX_KNOTS];
    logic [CNT_W-1:0]         knot_count;
    logic signed [DATA_W-1:0] pending_y [$];
    logic                     pending_hit [$];
    int                       errors;

    function new();
      knot_count = KNOT_COUNT_RESET;
      errors = 0;
    endfunction

    function void note_knot_count(input logic [CNT_W-1:0] v);
      knot_count = v;
    endfunction

    function void interpolate(input logic signed [DATA_W-1:0] q,
                              output logic signed [DATA_W-1:0] y, output logic hit);
      int n;
      int seg;
      bit done;
      longint x0, x1, y0, y1, dx, dy, dq, slope, r;
      n = int'(knot_count);
      if (n < KNOT_COUNT_MIN) n = KNOT_COUNT_MIN;
      if (n > KNOT_COUNT_MAX) n = KNOT_COUNT_MAX;
      hit = 1'b0;
      seg = 0;
      done = 1'b0;
      y = '0;
      for (int i = 1; i < n && !done; i++) begin
        if (q >= abscissa[i-1] && q <= abscissa[i]) begin
          seg = i;
          hit = 1'b1;
          done = 1'b1;
        end else if (q > abscissa[n-1] || q < abscissa[0]) begin
          done = 1'b1;
        end
      end
      if (hit) begin
        x0 = longint'(abscissa[seg-1]);
        x1 = longint'(abscissa[seg]);
        y0 = longint'(ordinate[seg-1]);
        y1 = longint'(ordinate[seg]);
        dx = x1 - x0;
        dy = y1 - y0;
        dq = longint'(q) - x0;
        slope = (dx != 0) ? (dy * 65536) / dx : 0;
        r = y0 + ((slope * dq) >>> FRAC_W);
        if (r > Y_MAX) r = Y_MAX;
        if (r < Y_MIN) r = Y_MIN;
        y = r[DATA_W-1:0];
      end
    endfunction

    function void take_item(input logic action, input logic [ADDR_W-1:0] idx,
                            input logic signed [DATA_W-1:0] kx, ky, qx);
      logic signed [DATA_W-1:0] y;
      logic hit;
      if (action == ACT_WRITE) begin
        abscissa[idx] = kx;
        ordinate[idx] = ky;
      end else begin
        interpolate(qx, y, hit);
        pending_y.push_back(y);
        pending_hit.push_back(hit);
      end
    endfunction

    function void check_answer(input logic signed [DATA_W-1:0] y, input logic hit);
      logic signed [DATA_W-1:0] want_y;
      logic want_hit;
      if (pending_y.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("Unexpected result word: value_y %h in_range %b", y, hit);
      end else begin
        want_y = pending_y.pop_front();
        want_hit = pending_hit.pop_front();
        if (y !== want_y || hit !== want_hit) begin
          errors++;
          if (errors <= 10)
            $display("Result word mismatch: value_y expected %h got %h, in_range expected %b got %b",
                     want_y, y, want_hit, hit);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_action = ACT_WRITE;
  logic [ADDR_W-1:0] in_knot_index = '0;
  logic signed [DATA_W-1:0] in_knot_x = '0;
  logic signed [DATA_W-1:0] in_knot_y = '0;
  logic signed [DATA_W-1:0] in_query_x = '0;
  logic out_valid;
  logic signed [DATA_W-1:0] out_value_y;
  logic out_in_range;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CNT_W-1:0] cfg_knot_count = '0;

  knot_interp_board board = new();

  int items_sent = 0;
  int burst_left = 0;
  int live_knots = 2;
  logic signed [DATA_W-1:0] plan_x [MAX_KNOTS];
  bit plan_loaded [MAX_KNOTS];

  piecewise_linear_interpolator dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_action      (in_action),
    .in_knot_index  (in_knot_index),
    .in_knot_x      (in_knot_x),
    .in_knot_y      (in_knot_y),
    .in_query_x     (in_query_x),
    .out_valid      (out_valid),
    .out_value_y    (out_value_y),
    .out_in_range   (out_in_range),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_knot_count (cfg_knot_count)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      board.check_answer(out_value_y, out_in_range);
    end
  end

  task automatic send_item(input logic action, input logic [ADDR_W-1:0] idx,
                           input logic signed [DATA_W-1:0] kx, ky, qx);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        @(negedge clk);
        start = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    start = 1'b1;
    in_action = action;
    in_knot_index = idx;
    in_knot_x = kx;
    in_knot_y = ky;
    in_query_x = qx;
    do @(posedge clk); while (busy);
    board.take_item(action, idx, kx, ky, qx);
    if (action == ACT_WRITE) begin
      plan_x[idx] = kx;
      plan_loaded[idx] = 1'b1;
    end
    items_sent++;
  endtask

  task automatic write_knot_count(input logic [CNT_W-1:0] v);
    @(negedge clk);
    start = 1'b0;
    burst_left = 0;
    while (board.pending_y.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_knot_count = v;
    do @(posedge clk); while (!cfg_ready);
    board.note_knot_count(v);
    live_knots = int'((v < KNOT_COUNT_MIN) ? KNOT_COUNT_MIN :
                      (v > KNOT_COUNT_MAX) ? KNOT_COUNT_MAX : v);
    @(negedge clk);
    cfg_valid = 1'b0;
    cfg_knot_count = CNT_W'($urandom);
  endtask

  initial begin
    #15_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int n, k, j, reps, pick, style;
    bit reload, backwards;
    longint cur, lo, hi, q;
    logic signed [DATA_W-1:0] fresh_x [MAX_KNOTS];
    logic [CNT_W-1:0] count_word;
    logic [ADDR_W-1:0] slot;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    write_knot_count(7'd2);
    send_item(ACT_WRITE, 6'd0, 32'sh8000_0000, 32'sh7FFF_FFFF, $urandom);
    send_item(ACT_WRITE, 6'd1, 32'sh7FFF_FFFF, 32'sh8000_0000, $urandom);
    send_item(ACT_QUERY, ADDR_W'($urandom), $urandom, $urandom, 32'sh8000_0000);
    send_item(ACT_QUERY, ADDR_W'($urandom), $urandom, $urandom, 32'sh7FFF_FFFF);
    send_item(ACT_QUERY, ADDR_W'($urandom), $urandom, $urandom, 32'sh0000_0000);
    send_item(ACT_QUERY, ADDR_W'($urandom), $urandom, $urandom, 32'shFFFF_FFFF);
    send_item(ACT_QUERY, ADDR_W'($urandom), $urandom, $urandom, 32'sh0001_8000);

    // A segment of zero width answers with its left ordinate.
    send_item(ACT_WRITE, 6'd0, 32'sh0005_0000, 32'sh0000_0007, $urandom);
    send_item(ACT_WRITE, 6'd1, 32'sh0005_0000, 32'sh0000_0063, $urandom);
    send_item(ACT_QUERY, ADDR_W'($urandom), $urandom, $urandom, 32'sh0005_0000);
    send_item(ACT_QUERY, ADDR_W'($urandom), $urandom, $urandom, 32'sh0004_FFFF);
    send_item(ACT_QUERY, ADDR_W'($urandom), $urandom, $urandom, 32'sh0005_0001);

    write_knot_count(7'd3);
    send_item(ACT_WRITE, 6'd2, 32'sh0008_0000, 32'shFFFD_0000, $urandom);
    send_item(ACT_QUERY, ADDR_W'($urandom), $urandom, $urandom, 32'sh0005_0000);
    send_item(ACT_QUERY, ADDR_W'($urandom), $urandom, $urandom, 32'sh0006_8000);
    send_item(ACT_QUERY, ADDR_W'($urandom), $urandom, $urandom, 32'sh0008_0000);

    // The last knot lies below the middle one, so the table is out of order.
    send_item(ACT_WRITE, 6'd0, 32'sh0000_0000, 32'sh0000_0000, $urandom);
    send_item(ACT_WRITE, 6'd1, 32'sh000A_0000, 32'sh0064_0000, $urandom);
    send_item(ACT_WRITE, 6'd2, 32'sh0004_0000, 32'shFFF0_0000, $urandom);
    send_item(ACT_QUERY, ADDR_W'($urandom), $urandom, $urandom, 32'sh0006_0000);
    send_item(ACT_QUERY, ADDR_W'($urandom), $urandom, $urandom, 32'sh000B_0000);

    write_knot_count(7'd0);
    send_item(ACT_QUERY, ADDR_W'($urandom), $urandom, $urandom, 32'sh0005_0000);
    write_knot_count(7'd1);
    send_item(ACT_QUERY, ADDR_W'($urandom), $urandom, $urandom, 32'sh0003_0000);

    while (items_sent < 1700) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0: count_word = 7'd0;
        1: count_word = 7'd1;
        2: count_word = 7'd2;
        3: count_word = 7'd64;
        4: count_word = 7'd127;
        5: count_word = CNT_W'($urandom_range(65, 126));
        default: count_word = CNT_W'($urandom_range(3, 63));
      endcase
      write_knot_count(count_word);
      n = live_knots;

      reload = ($urandom_range(0, 3) != 0);
      for (k = 0; k < n; k++) begin
        if (!plan_loaded[k]) reload = 1'b1;
      end
      if (reload) begin
        style = $urandom_range(0, 2);
        cur = (style == 0) ? Y_MIN + longint'($urandom_range(0, 32'h0100_0000))
                           : longint'($signed($urandom));
        for (k = 0; k < n; k++) begin
          if (k != 0) begin
            case (style)
              0: cur += longint'($urandom_range(0, 32'h0800_0000));
              1: cur += longint'($urandom_range(0, 3));
              default: cur += longint'($urandom_range(0, 32'h0004_0000));
            endcase
          end
          if (cur > Y_MAX) cur = Y_MAX;
          fresh_x[k] = cur[DATA_W-1:0];
        end
        backwards = 1'($urandom_range(0, 1));
        for (j = 0; j < n; j++) begin
          k = backwards ? n - 1 - j : j;
          send_item(ACT_WRITE, k[ADDR_W-1:0], fresh_x[k],
                    $urandom_range(0, 1) ? $urandom
                                         : $urandom_range(0, 32'h0010_0000) - 32'h0008_0000,
                    $urandom);
        end
      end

      reps = $urandom_range(15, 50);
      for (j = 0; j < reps; j++) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          slot = ADDR_W'($urandom);
          send_item(ACT_WRITE, slot, $urandom, $urandom, $urandom);
        end else begin
          if (pick < 60) begin
            k = $urandom_range(1, n - 1);
            lo = longint'(plan_x[k-1]);
            hi = longint'(plan_x[k]);
            q = lo + ((hi - lo) * longint'($urandom_range(0, 65536))) / 65536;
          end else if (pick < 75) begin
            q = longint'(plan_x[$urandom_range(0, n - 1)]);
          end else if (pick < 88) begin
            q = $urandom_range(0, 1) ? longint'(plan_x[0]) - 1 : longint'(plan_x[n-1]) + 1;
          end else begin
            q = longint'($signed($urandom));
          end
          if (q > Y_MAX) q = Y_MAX;
          if (q < Y_MIN) q = Y_MIN;
          send_item(ACT_QUERY, ADDR_W'($urandom), $urandom, $urandom, q[DATA_W-1:0]);
        end
      end
    end

    @(negedge clk);
    start = 1'b0;
    while (board.pending_y.size() != 0 || busy) @(posedge clk);
    repeat (200) @(posedge clk);
    if (board.pending_y.size() != 0) board.errors++;
    if (board.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
